### rtl/irpfd_pkg.sv
// Package for the IR pulse frame decoder: types, register map, status codes
// and the duration compare helpers. No dependencies.
package irpfd_pkg;

  localparam int DUR_W         = 15;
  localparam int CNT_W         = 7;
  localparam int PAYLOAD_W     = 64;
  localparam int WORD_W        = 16;
  localparam int FRAME_SYMBOLS = 68;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 3;
  localparam int POS_W         = $clog2(PAYLOAD_W);

  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] FRAME_LAST    = CNT_W'(FRAME_SYMBOLS - 1);
  localparam logic [CNT_W-1:0] DATA_A_FIRST  = CNT_W'(1);
  localparam logic [CNT_W-1:0] DATA_A_LAST   = CNT_W'(32);
  localparam logic [CNT_W-1:0] DATA_B_FIRST  = CNT_W'(35);
  localparam logic [CNT_W-1:0] DATA_B_LAST   = CNT_W'(66);
  localparam logic [CNT_W-1:0] DATA_B_OFFSET = CNT_W'(3);

  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_LEADER = 2'd2,
    ST_DATA   = 2'd3
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MARGIN       = 3'd0,
    REG_LEADER_MARK  = 3'd1,
    REG_LEADER_SPACE = 3'd2,
    REG_ZERO_MARK    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_MARK     = 3'd5,
    REG_ONE_SPACE    = 3'd6
  } reg_idx_t;

  localparam dur_t RST_MARGIN       = DUR_W'(350);
  localparam dur_t RST_LEADER_MARK  = DUR_W'(8250);
  localparam dur_t RST_LEADER_SPACE = DUR_W'(4200);
  localparam dur_t RST_ZERO_MARK    = DUR_W'(500);
  localparam dur_t RST_ZERO_SPACE   = DUR_W'(500);
  localparam dur_t RST_ONE_MARK     = DUR_W'(500);
  localparam dur_t RST_ONE_SPACE    = DUR_W'(1500);

  typedef struct packed {
    dur_t margin;
    dur_t leader_mark;
    dur_t leader_space;
    dur_t zero_mark;
    dur_t zero_space;
    dur_t one_mark;
    dur_t one_space;
  } cfg_t;

  typedef struct packed {
    logic leader_ok;
    logic one_ok;
    logic zero_ok;
    logic last;
  } sym_cls_t;

  typedef struct packed {
    logic pop;
    logic frame_end;
  } bk_stat_t;

  // n - m < d < n + m, evaluated one bit wider so neither bound wraps
  function automatic logic near_nominal(dur_t d, dur_t n, dur_t m);
    logic [DUR_W:0] dw;
    logic [DUR_W:0] nw;
    logic [DUR_W:0] mw;
    dw = {1'b0, d};
    nw = {1'b0, n};
    mw = {1'b0, m};
    return (dw < (nw + mw)) && ((dw + mw) > nw);
  endfunction

  function automatic logic [WORD_W-1:0] swap16(logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8]};
  endfunction

endpackage

### rtl/irpfd_if.sv
// Channel interfaces for the IR pulse frame decoder: symbol input and result output.
// Depends on irpfd_pkg.
interface irpfd_sym_if
  import irpfd_pkg::*;
;
  logic valid;
  logic ready;
  dur_t mark_time;
  dur_t space_time;
  logic last_symbol;

  modport source (output valid, mark_time, space_time, last_symbol, input ready);
  modport sink   (input valid, mark_time, space_time, last_symbol, output ready);
endinterface

interface irpfd_res_if
  import irpfd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [WORD_W-1:0]   address_first;
  logic [WORD_W-1:0]   command_first;
  logic [WORD_W-1:0]   address_second;
  logic [WORD_W-1:0]   command_second;

  modport source (output valid, status, address_first, command_first,
                  address_second, command_second, input ready);
  modport sink   (input valid, status, address_first, command_first,
                  address_second, command_second, output ready);
endinterface

### rtl/irpfd_cfg_regs.sv
// APB register bank holding margin and nominal durations.
// Depends on irpfd_pkg.
module irpfd_cfg_regs
  import irpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t           cfg_r;
  logic           wr_en;
  reg_idx_t       idx;
  dur_t           wval;
  dur_t           rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wval   = pwdata[DUR_W-1:0];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin       <= RST_MARGIN;
      cfg_r.leader_mark  <= RST_LEADER_MARK;
      cfg_r.leader_space <= RST_LEADER_SPACE;
      cfg_r.zero_mark    <= RST_ZERO_MARK;
      cfg_r.zero_space   <= RST_ZERO_SPACE;
      cfg_r.one_mark     <= RST_ONE_MARK;
      cfg_r.one_space    <= RST_ONE_SPACE;
    end else if (wr_en) begin
      unique case (idx)
        REG_MARGIN:       cfg_r.margin       <= wval;
        REG_LEADER_MARK:  cfg_r.leader_mark  <= wval;
        REG_LEADER_SPACE: cfg_r.leader_space <= wval;
        REG_ZERO_MARK:    cfg_r.zero_mark    <= wval;
        REG_ZERO_SPACE:   cfg_r.zero_space   <= wval;
        REG_ONE_MARK:     cfg_r.one_mark     <= wval;
        REG_ONE_SPACE:    cfg_r.one_space    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MARGIN:       rval = cfg_r.margin;
      REG_LEADER_MARK:  rval = cfg_r.leader_mark;
      REG_LEADER_SPACE: rval = cfg_r.leader_space;
      REG_ZERO_MARK:    rval = cfg_r.zero_mark;
      REG_ZERO_SPACE:   rval = cfg_r.zero_space;
      REG_ONE_MARK:     rval = cfg_r.one_mark;
      REG_ONE_SPACE:    rval = cfg_r.one_space;
      default:          rval = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-DUR_W){1'b0}}, rval};

endmodule

### rtl/irpfd_front.sv
// Front end: accepts symbol transactions and classifies them against the
// leader, one and zero patterns. Depends on irpfd_pkg and irpfd_if.
module irpfd_front
  import irpfd_pkg::*;
(
  irpfd_sym_if.sink in_sym,
  input  cfg_t      cfg,
  input  logic      q_full,
  output logic      push,
  output sym_cls_t  cls
);

  assign in_sym.ready = !q_full;
  assign push         = in_sym.valid && !q_full;

  always_comb begin
    cls.leader_ok = near_nominal(in_sym.mark_time, cfg.leader_mark, cfg.margin) &&
                    near_nominal(in_sym.space_time, cfg.leader_space, cfg.margin);
    cls.one_ok    = near_nominal(in_sym.mark_time, cfg.one_mark, cfg.margin) &&
                    near_nominal(in_sym.space_time, cfg.one_space, cfg.margin);
    cls.zero_ok   = near_nominal(in_sym.mark_time, cfg.zero_mark, cfg.margin) &&
                    near_nominal(in_sym.space_time, cfg.zero_space, cfg.margin);
    cls.last      = in_sym.last_symbol;
  end

endmodule

### rtl/irpfd_fifo.sv
// Short queue of classified symbols between front and back ends.
// Depends on irpfd_pkg.
module irpfd_fifo
  import irpfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sym_cls_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output sym_cls_t rdata
);

  sym_cls_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/irpfd_back.sv
// Back end: walks the frame symbol by symbol, collects payload bits, keeps the
// first error and registers one result per frame. Depends on irpfd_pkg and irpfd_if.
module irpfd_back
  import irpfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  sym_cls_t  head,
  output logic      pop,
  output bk_stat_t  stat,
  irpfd_res_if.source out_res
);

  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [PAYLOAD_W-1:0] bits_r,  bits_nxt;
  status_t              err_r,   err_nxt;
  logic                 valid_r, valid_nxt;
  status_t              status_r, status_nxt;
  logic [PAYLOAD_W-1:0] word_r,  word_nxt;

  logic [PAYLOAD_W-1:0] bits_step;
  status_t              err_step;
  status_t              fin_status;
  logic                 data_a;
  logic                 data_b;
  logic [CNT_W-1:0]     pos_full;
  logic [POS_W-1:0]     pos;

  assign pop            = !q_empty && (!head.last || !valid_r || out_res.ready);
  assign stat.pop       = pop;
  assign stat.frame_end = pop && head.last;

  assign data_a   = (cnt_r >= DATA_A_FIRST) && (cnt_r <= DATA_A_LAST);
  assign data_b   = (cnt_r >= DATA_B_FIRST) && (cnt_r <= DATA_B_LAST);
  assign pos_full = data_a ? (cnt_r - DATA_A_FIRST) : (cnt_r - DATA_B_OFFSET);
  assign pos      = pos_full[POS_W-1:0];

  always_comb begin
    bits_step = bits_r;
    err_step  = err_r;
    if (err_r == ST_OK) begin
      priority if (cnt_r == '0) begin
        if (!head.leader_ok) begin
          err_step = ST_LEADER;
        end
      end else if (data_a || data_b) begin
        priority if (head.one_ok) begin
          bits_step[pos] = 1'b1;
        end else if (head.zero_ok) begin
          bits_step[pos] = 1'b0;
        end else begin
          err_step = ST_DATA;
        end
      end else begin
      end
    end
    fin_status = (cnt_r != FRAME_LAST) ? ST_LENGTH : err_step;
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    err_nxt    = err_r;
    valid_nxt  = valid_r && !out_res.ready;
    status_nxt = status_r;
    word_nxt   = word_r;
    if (pop) begin
      if (head.last) begin
        valid_nxt  = 1'b1;
        status_nxt = fin_status;
        word_nxt   = (fin_status == ST_OK) ? bits_step : '0;
        cnt_nxt    = '0;
        bits_nxt   = '0;
        err_nxt    = ST_OK;
      end else begin
        cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
        bits_nxt = bits_step;
        err_nxt  = err_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      bits_r  <= '0;
      err_r   <= ST_OK;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      err_r   <= err_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    word_r   <= word_nxt;
  end

  assign out_res.valid          = valid_r;
  assign out_res.status         = status_r;
  assign out_res.address_first  = swap16(word_r[15:0]);
  assign out_res.command_first  = swap16(word_r[31:16]);
  assign out_res.address_second = swap16(word_r[47:32]);
  assign out_res.command_second = swap16(word_r[63:48]);

endmodule

### rtl/ir_pulse_frame_decoder_unit.sv
// IR pulse frame decoder top level: register bank, classifier, queue, frame back end.
// Symbols are queued; the back end registers the result when it pops the last symbol.
// Throughput: 1 symbol per cycle. While a result waits on out_res.ready the back end
// keeps consuming up to the next last symbol; the input stalls once 3 more fill the queue.
// Reset (rst_n low, synchronous): registers return to their defaults, the queue
// empties, the frame state clears and no result is pending.
module ir_pulse_frame_decoder_unit
  import irpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  irpfd_sym_if.sink          in_sym,
  irpfd_res_if.source        out_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg;
  sym_cls_t push_cls;
  sym_cls_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  bk_stat_t bk_stat;

  irpfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irpfd_front u_front (
    .in_sym (in_sym),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .cls    (push_cls)
  );

  irpfd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_cls),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rdata (head)
  );

  irpfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .stat    (bk_stat),
    .out_res (out_res)
  );

  a_err_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status != ST_OK) |->
      (out_res.address_first == '0 && out_res.command_first == '0 &&
       out_res.address_second == '0 && out_res.command_second == '0))
    else $error("error result carries nonzero words");

  a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(bk_stat.frame_end))
    else $error("result raised without a frame end");

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result pending after reset");

endmodule

### dv/testbench.sv
// Self-checking testbench for ir_pulse_frame_decoder_unit: symbol stream in,
// decoded frames out, checked against an in-bench frame decoder model.
// Depends on irpfd_pkg, the irpfd_sym_if / irpfd_res_if interfaces and the RTL.
`timescale 1ns / 100ps

module testbench;
  import irpfd_pkg::*;

  localparam int DUR_MAX       = (1 << DUR_W) - 1;
  localparam int REG_COUNT     = 7;
  localparam int SPARE_REG     = 7;
  localparam int REG_STRIDE    = 4;
  localparam int ITEM_TARGET   = 1850;
  localparam int PHASE_ITEMS   = 240;
  localparam int MAX_PHASES    = 30;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 100;

  localparam cfg_t DEFAULT_CFG = '{margin: RST_MARGIN, leader_mark: RST_LEADER_MARK,
                                   leader_space: RST_LEADER_SPACE,
                                   zero_mark: RST_ZERO_MARK, zero_space: RST_ZERO_SPACE,
                                   one_mark: RST_ONE_MARK, one_space: RST_ONE_SPACE};

  typedef enum {FR_CLEAN, FR_FLAWED, FR_SHORT, FR_LONG, FR_OVERRUN, FR_NOISE} frame_kind_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] addr_a;
    logic [WORD_W-1:0] cmd_a;
    logic [WORD_W-1:0] addr_b;
    logic [WORD_W-1:0] cmd_b;
  } frame_result_t;

  typedef struct packed {
    dur_t    mark;
    dur_t    space;
    logic    last;
    logic    typed;
    status_t want_status;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  irpfd_sym_if sym_ch ();
  irpfd_res_if res_ch ();

  ir_pulse_frame_decoder_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_sym  (sym_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t             decoder_cfg = DEFAULT_CFG;
  logic [CNT_W-1:0] frame_symbols = '0;
  logic [63:0]      frame_bits = '0;
  status_t          frame_error = ST_OK;
  frame_result_t    pending_frames[$];

  int symbols_sent   = 0;
  int mismatch_count = 0;
  bit steady_source  = 1'b0;

  dir_row_t directed_rows [14] = '{
    '{15'd8250,  15'd4200,  1'b0, 1'b0, ST_OK},
    '{15'd32767, 15'd32767, 1'b1, 1'b1, ST_LENGTH},
    '{15'd0,     15'd0,     1'b1, 1'b1, ST_LENGTH},
    '{15'd32767, 15'd0,     1'b1, 1'b1, ST_LENGTH},
    '{15'd0,     15'd32767, 1'b0, 1'b0, ST_OK},
    '{15'd7901,  15'd3851,  1'b0, 1'b0, ST_OK},
    '{15'd849,   15'd1849,  1'b0, 1'b0, ST_OK},
    '{15'd151,   15'd151,   1'b0, 1'b0, ST_OK},
    '{15'd150,   15'd500,   1'b0, 1'b0, ST_OK},
    '{15'd850,   15'd1500,  1'b1, 1'b1, ST_LENGTH},
    '{15'd8600,  15'd4200,  1'b1, 1'b1, ST_LENGTH},
    '{15'd8599,  15'd4549,  1'b0, 1'b0, ST_OK},
    '{15'd500,   15'd1500,  1'b0, 1'b0, ST_OK},
    '{15'd500,   15'd500,   1'b1, 1'b1, ST_LENGTH}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** ir_pulse_frame_decoder_unit: FAILED **");
    $finish;
  end

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  function automatic logic in_window(dur_t d, dur_t nominal);
    int lo;
    int hi;
    lo = int'(nominal) - int'(decoder_cfg.margin);
    hi = int'(nominal) + int'(decoder_cfg.margin);
    return (int'(d) > lo) && (int'(d) < hi);
  endfunction

  // bit position carried by a symbol index, -1 where the symbol carries none
  function automatic int payload_pos(int idx);
    if (idx >= 1 && idx <= 32) return idx - 1;
    if (idx >= 35 && idx <= 66) return idx - 3;
    return -1;
  endfunction

  function automatic logic decode_symbol(dur_t mk, dur_t sp, logic last,
                                         output frame_result_t res);
    int idx;
    int pos;
    idx = frame_symbols;
    pos = payload_pos(idx);
    res = '0;
    if (frame_error == ST_OK) begin
      if (idx == 0) begin
        if (!(in_window(mk, decoder_cfg.leader_mark) && in_window(sp, decoder_cfg.leader_space)))
          frame_error = ST_LEADER;
      end else if (pos >= 0) begin
        if (in_window(mk, decoder_cfg.one_mark) && in_window(sp, decoder_cfg.one_space))
          frame_bits[pos] = 1'b1;
        else if (in_window(mk, decoder_cfg.zero_mark) && in_window(sp, decoder_cfg.zero_space))
          frame_bits[pos] = 1'b0;
        else
          frame_error = ST_DATA;
      end
    end
    if (!last) begin
      if (frame_symbols != CNT_MAX) frame_symbols++;
      return 1'b0;
    end
    res.status = (idx + 1 != FRAME_SYMBOLS) ? ST_LENGTH : frame_error;
    if (res.status == ST_OK) begin
      res.addr_a = {frame_bits[7:0], frame_bits[15:8]};
      res.cmd_a  = {frame_bits[23:16], frame_bits[31:24]};
      res.addr_b = {frame_bits[39:32], frame_bits[47:40]};
      res.cmd_b  = {frame_bits[55:48], frame_bits[63:56]};
    end
    frame_symbols = '0;
    frame_bits    = '0;
    frame_error   = ST_OK;
    return 1'b1;
  endfunction

  function automatic dur_t near_value(dur_t nominal);
    int lo;
    int hi;
    lo = int'(nominal) - int'(decoder_cfg.margin) + 1;
    hi = int'(nominal) + int'(decoder_cfg.margin) - 1;
    if (lo < 0) lo = 0;
    if (hi > DUR_MAX) hi = DUR_MAX;
    if (lo > hi) return dur_t'($urandom_range(0, DUR_MAX));
    case ($urandom_range(0, 9))
      0: return dur_t'(lo);
      1: return dur_t'(hi);
      default: return dur_t'($urandom_range(lo, hi));
    endcase
  endfunction

  // just outside the window unless clamped to the duration range: the bounds are strict
  function automatic dur_t edge_value(dur_t nominal);
    int v;
    v = $urandom_range(0, 1) ? int'(nominal) + int'(decoder_cfg.margin)
                             : int'(nominal) - int'(decoder_cfg.margin);
    if (v < 0) v = 0;
    if (v > DUR_MAX) v = DUR_MAX;
    return dur_t'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_source) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FR_CLEAN;
    if (r < 70) return FR_FLAWED;
    if (r < 80) return FR_SHORT;
    if (r < 87) return FR_LONG;
    if (r < 89) return FR_OVERRUN;
    return FR_NOISE;
  endfunction

  function automatic dur_t cfg_field(cfg_t c, int idx);
    case (idx)
      REG_MARGIN:       return c.margin;
      REG_LEADER_MARK:  return c.leader_mark;
      REG_LEADER_SPACE: return c.leader_space;
      REG_ZERO_MARK:    return c.zero_mark;
      REG_ZERO_SPACE:   return c.zero_space;
      REG_ONE_MARK:     return c.one_mark;
      REG_ONE_SPACE:    return c.one_space;
      default:          return '0;
    endcase
  endfunction

  function automatic cfg_t pick_settings(int ph);
    cfg_t c;
    case (ph)
      1: begin
        c = DEFAULT_CFG;
        c.margin = '0;
      end
      2: c = '1;
      3: c = '{margin: 15'd300, leader_mark: 15'd9000, leader_space: 15'd4500,
               zero_mark: 15'd0, zero_space: 15'd100, one_mark: 15'd0, one_space: 15'd600};
      4: c = DEFAULT_CFG;
      default: begin
        c.margin       = dur_t'($urandom_range(20, 700));
        c.leader_mark  = dur_t'($urandom_range(3000, 32000));
        c.leader_space = dur_t'($urandom_range(1500, 16000));
        c.zero_mark    = dur_t'($urandom_range(100, 3000));
        c.zero_space   = dur_t'($urandom_range(100, 3000));
        c.one_mark     = dur_t'($urandom_range(100, 3000));
        c.one_space    = dur_t'($urandom_range(100, 6000));
      end
    endcase
    return c;
  endfunction

  task automatic apb_access(logic wr, int idx, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(idx * REG_STRIDE);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done  = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(cfg_t next_cfg);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    int idx;
    for (idx = 0; idx < REG_COUNT; idx++) begin
      wdata = $urandom();
      wdata[DUR_W-1:0] = cfg_field(next_cfg, idx);
      apb_access(1'b1, idx, wdata, rdata);
    end
    apb_access(1'b1, SPARE_REG, $urandom(), rdata);
    decoder_cfg = next_cfg;
    for (idx = 0; idx < REG_COUNT; idx++) begin
      apb_access(1'b0, idx, '0, rdata);
      if (rdata !== PDATA_W'(cfg_field(decoder_cfg, idx)))
        log_mismatch($sformatf("register %0d reads %h, want %h", idx, rdata,
                               cfg_field(decoder_cfg, idx)));
    end
  endtask

  task automatic offer_symbol(dur_t mk, dur_t sp, logic last);
    int gap;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      sym_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_ch.valid       <= 1'b1;
    sym_ch.mark_time   <= mk;
    sym_ch.space_time  <= sp;
    sym_ch.last_symbol <= last;
    do begin
      @(negedge clk);
      taken = sym_ch.ready;
      @(posedge clk);
    end while (!taken);
    symbols_sent++;
  endtask

  task automatic send_symbol(dur_t mk, dur_t sp, logic last);
    frame_result_t res;
    offer_symbol(mk, sp, last);
    if (decode_symbol(mk, sp, last, res)) pending_frames.push_back(res);
  endtask

  task automatic send_frame(frame_kind_t kind);
    int len;
    int flaw;
    int i;
    dur_t mk;
    dur_t sp;
    dur_t nom_mk;
    dur_t nom_sp;
    steady_source = ($urandom_range(0, 4) == 0);
    case (kind)
      FR_CLEAN, FR_FLAWED: len = FRAME_SYMBOLS;
      FR_SHORT:            len = $urandom_range(2, FRAME_SYMBOLS - 1);
      FR_LONG:             len = $urandom_range(FRAME_SYMBOLS + 1, FRAME_SYMBOLS + 12);
      FR_OVERRUN:          len = $urandom_range(128, 140);
      default:             len = $urandom_range(1, 6);
    endcase
    flaw = (kind == FR_FLAWED) ? $urandom_range(0, FRAME_SYMBOLS - 1) : -1;
    for (i = 0; i < len; i++) begin
      if (i == 0) begin
        nom_mk = decoder_cfg.leader_mark;
        nom_sp = decoder_cfg.leader_space;
      end else if ($urandom_range(0, 1)) begin
        nom_mk = decoder_cfg.one_mark;
        nom_sp = decoder_cfg.one_space;
      end else begin
        nom_mk = decoder_cfg.zero_mark;
        nom_sp = decoder_cfg.zero_space;
      end
      mk = near_value(nom_mk);
      sp = near_value(nom_sp);
      if (kind == FR_NOISE || (i != 0 && payload_pos(i) < 0)) begin
        mk = dur_t'($urandom_range(0, DUR_MAX));
        sp = dur_t'($urandom_range(0, DUR_MAX));
      end
      if (i == flaw) begin
        case ($urandom_range(0, 2))
          0: mk = edge_value(nom_mk);
          1: sp = edge_value(nom_sp);
          default: begin
            mk = dur_t'($urandom_range(0, DUR_MAX));
            sp = dur_t'($urandom_range(0, DUR_MAX));
          end
        endcase
      end
      send_symbol(mk, sp, i == len - 1);
    end
  endtask

  task automatic settle();
    sym_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_frames.size() == 0) begin
      log_mismatch($sformatf("result with none expected, status %0d", res_ch.status));
      return;
    end
    want = pending_frames.pop_front();
    if (res_ch.status !== want.status)
      log_mismatch($sformatf("status %0d, want %0d", res_ch.status, want.status));
    if (res_ch.address_first !== want.addr_a)
      log_mismatch($sformatf("address_first %h, want %h", res_ch.address_first, want.addr_a));
    if (res_ch.command_first !== want.cmd_a)
      log_mismatch($sformatf("command_first %h, want %h", res_ch.command_first, want.cmd_a));
    if (res_ch.address_second !== want.addr_b)
      log_mismatch($sformatf("address_second %h, want %h", res_ch.address_second, want.addr_b));
    if (res_ch.command_second !== want.cmd_b)
      log_mismatch($sformatf("command_second %h, want %h", res_ch.command_second, want.cmd_b));
  endtask

  // inputs only move at the rising edge, so a transaction seen here completes at the next one
  always @(negedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) check_result();
  end

  initial begin : result_sink
    int hold;
    int span;
    logic smooth;
    hold   = 0;
    span   = 0;
    smooth = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span   = $urandom_range(100, 600);
        smooth = ($urandom_range(0, 3) == 0);
      end
      span--;
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else if (!smooth && $urandom_range(0, 99) < 15) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    frame_result_t res;
    logic has_result;
    int ph;
    int phase_end;
    rst_n              <= 1'b0;
    sym_ch.valid       <= 1'b0;
    sym_ch.mark_time   <= '0;
    sym_ch.space_time  <= '0;
    sym_ch.last_symbol <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_symbol(directed_rows[i].mark, directed_rows[i].space, directed_rows[i].last);
      has_result = decode_symbol(directed_rows[i].mark, directed_rows[i].space,
                                 directed_rows[i].last, res);
      if (directed_rows[i].typed)
        pending_frames.push_back('{directed_rows[i].want_status, 16'h0, 16'h0, 16'h0, 16'h0});
      else if (has_result)
        pending_frames.push_back(res);
    end

    // drive the symbol counter into saturation with one overrun frame
    send_frame(FR_OVERRUN);

    ph = 0;
    while (ph < MAX_PHASES && symbols_sent < ITEM_TARGET) begin
      if (ph > 0) begin
        settle();
        load_settings(pick_settings(ph));
      end
      phase_end = symbols_sent + PHASE_ITEMS;
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (symbols_sent < phase_end) send_frame(pick_kind());
      ph++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** ir_pulse_frame_decoder_unit: PASSED **");
    end else begin
      $display("** ir_pulse_frame_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/irpfd_pkg.sv
rtl/irpfd_if.sv
rtl/irpfd_cfg_regs.sv
rtl/irpfd_front.sv
rtl/irpfd_fifo.sv
rtl/irpfd_back.sv
rtl/ir_pulse_frame_decoder_unit.sv
dv/testbench.sv
